// ----- rtl/hvt_pkg.sv -----
`timescale 1ns / 1ps
package hvt_pkg;
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int ACC_BITS = 2 * WORD_BITS + 2;
   localparam int NUM_BITS = WORD_BITS + FRAC_BITS;
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_POINT = 2'd1;
   localparam logic [1:0] OP_DIR = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [WORD_BITS-1:0] ONE_Q = WORD_BITS'(1) << FRAC_BITS;

   typedef struct packed {
      logic [1:0] operation;
      logic [3:0] entry_index;
      logic signed [WORD_BITS-1:0] entry_value;
      logic signed [WORD_BITS-1:0] in_x;
      logic signed [WORD_BITS-1:0] in_y;
      logic signed [WORD_BITS-1:0] in_z;
   } item_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] out_x;
      logic signed [WORD_BITS-1:0] out_y;
      logic signed [WORD_BITS-1:0] out_z;
      logic was_divided;
      logic saturated;
   } result_type;
endpackage

// ----- rtl/hvt_front.sv -----
`timescale 1ns / 1ps
// Accepts requests, drops unused codes and holds a two-entry queue.
module hvt_front (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  hvt_pkg::item_type in_item,
   output logic q_valid,
   input  logic q_ready,
   output hvt_pkg::item_type q_item
);
   hvt_pkg::item_type mem_ff [2];
   hvt_pkg::item_type mem_in [2];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready && (in_item.operation != hvt_pkg::OP_UNUSED);
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_item = mem_ff[rp_ff];

   always_comb begin
      mem_in = mem_ff;
      if (push) begin
         mem_in[wp_ff] = in_item;
      end
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

// ----- rtl/hvt_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit a cycle: (num << FRAC_BITS) / den.
module hvt_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [hvt_pkg::WORD_BITS-1:0] num,
   input  logic signed [hvt_pkg::WORD_BITS-1:0] den,
   output logic done,
   output logic signed [hvt_pkg::WORD_BITS-1:0] quo,
   output logic clip
);
   localparam int NB = hvt_pkg::NUM_BITS;
   localparam int W = hvt_pkg::WORD_BITS;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [$clog2(NB+1)-1:0] cnt_ff, cnt_in;
   logic [NB-1:0] n_ff, n_in, q_ff, q_in;
   logic [W:0] rem_ff, rem_in, trial;
   logic [W-1:0] d_ff, d_in;
   logic neg_ff, neg_in;
   logic [NB:0] mag;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      n_in = n_ff;
      q_in = q_ff;
      rem_in = rem_ff;
      d_in = d_ff;
      neg_in = neg_ff;
      trial = {rem_ff[W-1:0], n_ff[NB-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         n_in = NB'(num[W-1] ? -{{(NB-W){num[W-1]}}, num} : {{(NB-W){1'b0}}, num})
            << hvt_pkg::FRAC_BITS;
         d_in = den[W-1] ? W'(-den) : den;
         rem_in = '0;
         q_in = '0;
         neg_in = num[W-1] ^ den[W-1];
      end else if (busy_ff) begin
         n_in = n_ff << 1;
         if (trial >= {1'b0, d_ff}) begin
            rem_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[NB-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ($bits(cnt_ff))'(NB - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      mag = {1'b0, q_ff};
      clip = 1'b0;
      if (neg_ff) begin
         if (mag > (NB+1)'({1'b1, {(W-1){1'b0}}})) begin
            clip = 1'b1;
            quo = {1'b1, {(W-1){1'b0}}};
         end else begin
            quo = W'(-q_ff);
         end
      end else if (mag > (NB+1)'({1'b0, {(W-1){1'b1}}})) begin
         clip = 1'b1;
         quo = {1'b0, {(W-1){1'b1}}};
      end else begin
         quo = q_ff[W-1:0];
      end
   end
   assign done = done_ff;

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      q_ff <= q_in;
      rem_ff <= rem_in;
      d_ff <= d_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
endmodule

// ----- rtl/hvt_back.sv -----
`timescale 1ns / 1ps
// Holds the matrix, runs one shared multiply-accumulate over the sixteen
// products, divides a point with w not 0 or 1.0, and drives a registered result.
module hvt_back (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_ready,
   input  hvt_pkg::item_type q_item,
   output logic out_valid,
   input  logic out_ready,
   output hvt_pkg::result_type out_res
);
   localparam int W = hvt_pkg::WORD_BITS;
   localparam int AB = hvt_pkg::ACC_BITS;
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MAC = 3'd1;
   localparam logic [2:0] ST_SUM = 3'd2;
   localparam logic [2:0] ST_DIV = 3'd3;
   localparam logic [2:0] ST_WAIT = 3'd4;
   localparam logic [2:0] ST_OUT = 3'd5;
   localparam logic signed [AB-1:0] ACC_MAX = AB'({1'b0, {(W-1){1'b1}}});
   localparam logic signed [AB-1:0] ACC_MIN = ~ACC_MAX;

   logic [2:0] st_ff, st_in;
   logic signed [W-1:0] mat_ff [16];
   logic signed [W-1:0] mat_in [16];
   logic signed [W-1:0] vec_ff [4];
   logic signed [W-1:0] vec_in [4];
   logic signed [W-1:0] comp_ff [4];
   logic signed [W-1:0] comp_in [4];
   logic [3:0] k_ff, k_in;
   logic [1:0] dk_ff, dk_in;
   logic signed [2*W-1:0] prod_ff, prod_in;
   logic pv_ff, pv_in;
   logic [1:0] prow_ff, prow_in, pcol_ff, pcol_in;
   logic signed [AB-1:0] acc_ff, acc_in, acc_next;
   logic pt_ff, pt_in, clip_ff, clip_in, divd_ff, divd_in;
   logic div_start, div_done, div_clip;
   logic signed [W-1:0] div_quo;
   hvt_pkg::result_type res_ff, res_in;
   logic signed [W-1:0] sat_val;
   logic sat_clip;

   hvt_div u_div (.clock(clock), .reset(reset), .start(div_start), .num(comp_ff[dk_ff]),
      .den(comp_ff[3]), .done(div_done), .quo(div_quo), .clip(div_clip));

   assign q_ready = (st_ff == ST_IDLE) || (st_ff == ST_OUT && out_ready);
   assign out_valid = (st_ff == ST_OUT);
   assign out_res = res_ff;
   assign acc_next = acc_ff + AB'(prod_ff >>> hvt_pkg::FRAC_BITS);

   always_comb begin
      if (acc_next > ACC_MAX) begin
         sat_val = {1'b0, {(W-1){1'b1}}};
         sat_clip = 1'b1;
      end else if (acc_next < ACC_MIN) begin
         sat_val = {1'b1, {(W-1){1'b0}}};
         sat_clip = 1'b1;
      end else begin
         sat_val = acc_next[W-1:0];
         sat_clip = 1'b0;
      end
   end

   always_comb begin
      st_in = st_ff;
      mat_in = mat_ff;
      vec_in = vec_ff;
      comp_in = comp_ff;
      k_in = k_ff;
      dk_in = dk_ff;
      prod_in = $signed(mat_ff[{k_ff[1:0], k_ff[3:2]}]) * $signed(vec_ff[k_ff[1:0]]);
      pv_in = 1'b0;
      prow_in = k_ff[3:2];
      pcol_in = k_ff[1:0];
      acc_in = acc_ff;
      pt_in = pt_ff;
      clip_in = clip_ff;
      divd_in = divd_ff;
      res_in = res_ff;
      div_start = 1'b0;
      if (st_ff == ST_OUT && out_ready) begin
         st_in = ST_IDLE;
      end
      if (q_ready && q_valid) begin
         if (q_item.operation == hvt_pkg::OP_LOAD) begin
            mat_in[q_item.entry_index] = q_item.entry_value;
         end else begin
            vec_in[0] = q_item.in_x;
            vec_in[1] = q_item.in_y;
            vec_in[2] = q_item.in_z;
            vec_in[3] = (q_item.operation == hvt_pkg::OP_POINT) ? hvt_pkg::ONE_Q : '0;
            pt_in = (q_item.operation == hvt_pkg::OP_POINT);
            k_in = '0;
            clip_in = 1'b0;
            divd_in = 1'b0;
            acc_in = '0;
            st_in = ST_MAC;
         end
      end
      case (st_ff)
         ST_MAC, ST_SUM: begin
            if (st_ff == ST_MAC) begin
               pv_in = 1'b1;
               k_in = k_ff + 4'd1;
               if (k_ff == 4'd15) begin
                  st_in = ST_SUM;
               end
            end
            if (pv_ff) begin
               if (pcol_ff == 2'd3) begin
                  comp_in[prow_ff] = sat_val;
                  clip_in = clip_ff | sat_clip;
                  acc_in = '0;
               end else begin
                  acc_in = acc_next;
               end
               if (st_ff == ST_SUM) begin
                  if (pt_ff && sat_val != '0 && sat_val != hvt_pkg::ONE_Q) begin
                     dk_in = 2'd0;
                     divd_in = 1'b1;
                     st_in = ST_DIV;
                  end else begin
                     st_in = ST_WAIT;
                  end
               end
            end
         end
         ST_DIV: begin
            div_start = 1'b1;
            st_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (!divd_ff || div_done) begin
               if (divd_ff) begin
                  comp_in[dk_ff] = div_quo;
                  clip_in = clip_ff | div_clip;
               end
               if (divd_ff && dk_ff != 2'd2) begin
                  dk_in = dk_ff + 2'd1;
                  st_in = ST_DIV;
               end else begin
                  res_in.out_x = divd_ff && dk_ff == 2'd0 ? div_quo : comp_ff[0];
                  res_in.out_y = divd_ff && dk_ff == 2'd1 ? div_quo : comp_ff[1];
                  res_in.out_z = divd_ff ? div_quo : comp_ff[2];
                  res_in.was_divided = divd_ff;
                  res_in.saturated = clip_ff | (divd_ff & div_clip);
                  st_in = ST_OUT;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
      comp_ff <= comp_in;
      k_ff <= k_in;
      dk_ff <= dk_in;
      prod_ff <= prod_in;
      prow_ff <= prow_in;
      pcol_ff <= pcol_in;
      acc_ff <= acc_in;
      pt_ff <= pt_in;
      clip_ff <= clip_in;
      divd_ff <= divd_in;
      res_ff <= res_in;
      if (reset) begin
         st_ff <= ST_IDLE;
         pv_ff <= 1'b0;
         for (int i = 0; i < 16; i++) begin
            mat_ff[i] <= (i % 5 == 0) ? hvt_pkg::ONE_Q : '0;
         end
      end else begin
         st_ff <= st_in;
         pv_ff <= pv_in;
         mat_ff <= mat_in;
      end
   end
endmodule

// ----- rtl/homogeneous_vertex_transform_top.sv -----
`timescale 1ns / 1ps
// Transforms vertices by a 4x4 Q16.16 matrix (identity after reset). A load
// request writes one entry and gives no response; a point or direction
// request gives one response. One shared multiplier forms the sixteen
// products of a transform one after another, then the sums are finished;
// a point with w other than 0 and 1.0 then goes through three divides, one
// per component. A two-entry queue sits in front.
module homogeneous_vertex_transform_top (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // tdata: entry_index, entry_value, in_x, in_y, in_z, zero fill.
   input  logic [135:0] req_tdata,
   // tuser: operation.
   input  logic [1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tdata: out_x, out_y, out_z.
   output logic [95:0] rsp_tdata,
   // tuser: was_divided, saturated.
   output logic [1:0] rsp_tuser
);
   hvt_pkg::item_type in_item, q_item;
   hvt_pkg::result_type res;
   logic q_valid, q_ready;

   assign in_item.operation = req_tuser;
   assign in_item.entry_index = req_tdata[3:0];
   assign in_item.entry_value = req_tdata[35:4];
   assign in_item.in_x = req_tdata[67:36];
   assign in_item.in_y = req_tdata[99:68];
   assign in_item.in_z = req_tdata[131:100];

   hvt_front u_front (.clock(clock), .reset(reset), .in_valid(req_tvalid),
      .in_ready(req_tready), .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready),
      .q_item(q_item));
   hvt_back u_back (.clock(clock), .reset(reset), .q_valid(q_valid), .q_ready(q_ready),
      .q_item(q_item), .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_res(res));

   assign rsp_tdata = {res.out_z, res.out_y, res.out_x};
   assign rsp_tuser = {res.saturated, res.was_divided};
endmodule

// ----- rtl/hvt_checker.sv -----
`timescale 1ns / 1ps
module hvt_checker (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic [1:0] rsp_tuser
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response dropped while stalled");
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("response after reset");
   a_ready: assert property (@(posedge clock) $past(reset) |-> req_tready)
      else $error("not ready after reset");
   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("back-to-back responses");
endmodule

bind homogeneous_vertex_transform_top hvt_checker u_chk (.clock(clock), .reset(reset),
   .req_tready(req_tready), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser));
